FILE: sv/lmm4_pkg.sv
// Shared types, constants and helpers for the 4-neighbor local maximum mask unit.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package lmm4_pkg;

  // Geometry and sample size
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int PIXEL_BITS = 16;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int FW_W       = 11;  // frame_width register
  localparam int FH_W       = 13;  // frame_height register
  localparam int MIN_DIM    = 3;

  // Result queue
  localparam int FIFO_DEPTH = 4;
  localparam int FPTR_W     = $clog2(FIFO_DEPTH);
  localparam int FCNT_W     = FPTR_W + 1;

  // Configuration port
  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_PIXEL_SIGNED = 2'd2
  } cfg_reg_e;

  // One line store entry: the column's two previous rows
  typedef struct packed {
    logic [PIXEL_BITS-1:0] older;
    logic [PIXEL_BITS-1:0] newer;
  } line_entry_t;

  // One mask result
  typedef struct packed {
    logic             is_max;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             done;
  } result_t;

  // Unsigned key with the same ordering as the sample under the chosen mode
  function automatic logic [PIXEL_BITS-1:0] order_key(input logic [PIXEL_BITS-1:0] v,
                                                      input logic sgn);
    return {v[PIXEL_BITS-1] ^ sgn, v[PIXEL_BITS-2:0]};
  endfunction

endpackage

FILE: sv/lmm4_line_store.sv
// Line store: one memory holding the two previous rows per column.
// One write port and two registered read ports. Depends on lmm4_pkg.
`timescale 1ns / 1ps

module lmm4_line_store
  import lmm4_pkg::*;
(
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [COL_W-1:0]  wr_addr_i,
  input  line_entry_t       wr_data_i,
  input  logic [COL_W-1:0]  rd_a_addr_i,
  input  logic [COL_W-1:0]  rd_b_addr_i,
  output line_entry_t       rd_a_data_o,
  output line_entry_t       rd_b_data_o
);

  line_entry_t mem [MAX_WIDTH];
  line_entry_t rd_a_q, rd_b_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read ports
  always_ff @(posedge clk_i) begin
    rd_a_q <= mem[rd_a_addr_i];
    rd_b_q <= mem[rd_b_addr_i];
  end

  assign rd_a_data_o = rd_a_q;
  assign rd_b_data_o = rd_b_q;

endmodule

FILE: sv/lmm4_result_fifo.sv
// Result queue: takes up to two mask results per cycle, gives one per cycle unless the output is stalled.
// Depends on lmm4_pkg.
`timescale 1ns / 1ps

module lmm4_result_fifo
  import lmm4_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push0_i,
  input  result_t data0_i,
  input  logic    push1_i,
  input  result_t data1_i,
  output logic    room2_o,
  output logic    valid_o,
  output result_t data_o,
  input  logic    stall_i
);

  result_t entries [FIFO_DEPTH];
  logic [FPTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [FCNT_W-1:0] count_q, count_d;
  logic [FCNT_W-1:0] n_push;
  logic              pop;

  assign pop    = (count_q != '0) && !stall_i;
  assign n_push = FCNT_W'(push0_i) + FCNT_W'(push1_i);

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q + FPTR_W'(n_push);
    rd_ptr_d = rd_ptr_q + FPTR_W'(pop);
    count_d  = count_q + n_push - FCNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push0_i) begin
      entries[wr_ptr_q] <= data0_i;
    end
    if (push1_i) begin
      entries[wr_ptr_q + FPTR_W'(1)] <= data1_i;
    end
  end

  assign room2_o = count_q <= FCNT_W'(FIFO_DEPTH - 2);
  assign valid_o = count_q != '0;
  assign data_o  = entries[rd_ptr_q];

endmodule

FILE: sv/local_maximum_mask_4_neighbor_unit.sv
// Top level of the 4-neighbor local maximum mask unit: counters, window compare,
// APB registers. Depends on lmm4_pkg, lmm4_line_store and lmm4_result_fifo.
//
//  Port group | Direction | Handshake                   | Payload
//  -----------+-----------+-----------------------------+------------------------------
//  pixel in   | in        | in_valid_i / in_stall_o     | pixel_value_i
//  mask out   | out       | out_valid_o / out_stall_i   | is_local_max_o, out_row_o,
//             |           |                             | out_column_o, frame_done_o
//  config     | in/out    | psel, penable, pready       | paddr, pwdata, prdata
//
// One pixel per cycle unless the input stalls. Pixels of the last row give two
// results each and the output drains at most one per cycle, so there the result
// queue holds the input back. A result enters the queue on its pixel transfer.
// After reset and after a frame_width or frame_height write the input stalls
// while the line store read ports load the first columns. The four-entry result
// queue keeps taking pixels during an output stall while two entries are free.
`timescale 1ns / 1ps

module local_maximum_mask_4_neighbor_unit
  import lmm4_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // pixel input
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [PIXEL_BITS-1:0] pixel_value_i,
  // mask output
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  is_local_max_o,
  output logic [ROW_W-1:0]      out_row_o,
  output logic [COL_W-1:0]      out_column_o,
  output logic                  frame_done_o,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_AW-1:0]     paddr,
  input  logic [APB_DW-1:0]     pwdata,
  output logic [APB_DW-1:0]     prdata,
  output logic                  pready
);

  // Configuration registers
  logic [FW_W-1:0] frame_width_q;
  logic [FH_W-1:0] frame_height_q;
  logic            pixel_signed_q;
  logic            cfg_wr;
  logic            geom_wr;
  cfg_reg_e        cfg_sel;

  // Position and control
  logic [COL_W-1:0] col_q;
  logic [ROW_W-1:0] row_q;
  logic             rd_valid_q;
  logic             accept;
  logic             room2;

  // Geometry
  logic [FW_W-1:0]  eff_w;
  logic [FH_W-1:0]  eff_h;
  logic             last_col, next_last_col, last_row;
  logic [COL_W-1:0] col_p1, col_p2;

  // Window
  line_entry_t           cur_entry, nxt_entry, wr_entry;
  logic [COL_W-1:0]      rd_a_addr, rd_b_addr;
  logic [PIXEL_BITS-1:0] left_q;
  logic [PIXEL_BITS-1:0] k_ctr;
  logic                  interior, is_max;

  // Results
  result_t res0, res1, res_out;
  logic    push0, push1;

  // APB register file
  assign pready  = 1'b1;
  assign cfg_sel = cfg_reg_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;
  assign geom_wr = cfg_wr && (cfg_sel == REG_FRAME_WIDTH || cfg_sel == REG_FRAME_HEIGHT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FW_W'(640);
      frame_height_q <= FH_W'(480);
      pixel_signed_q <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_FRAME_WIDTH:  frame_width_q  <= pwdata[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height_q <= pwdata[FH_W-1:0];
        REG_PIXEL_SIGNED: pixel_signed_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_FRAME_WIDTH:  prdata = APB_DW'(frame_width_q);
      REG_FRAME_HEIGHT: prdata = APB_DW'(frame_height_q);
      REG_PIXEL_SIGNED: prdata = APB_DW'(pixel_signed_q);
      default:          prdata = '0;
    endcase
  end

  // Clamp geometry to the supported range
  always_comb begin
    if (frame_width_q < FW_W'(MIN_DIM)) begin
      eff_w = FW_W'(MIN_DIM);
    end else if (frame_width_q > FW_W'(MAX_WIDTH)) begin
      eff_w = FW_W'(MAX_WIDTH);
    end else begin
      eff_w = frame_width_q;
    end
    if (frame_height_q < FH_W'(MIN_DIM)) begin
      eff_h = FH_W'(MIN_DIM);
    end else if (frame_height_q > FH_W'(MAX_HEIGHT)) begin
      eff_h = FH_W'(MAX_HEIGHT);
    end else begin
      eff_h = frame_height_q;
    end
  end

  // Column lookahead; rows are at least three wide so wrap targets never collide
  assign last_col      = (FW_W'(col_q) + FW_W'(1)) == eff_w;
  assign next_last_col = (FW_W'(col_q) + FW_W'(2)) == eff_w;
  assign last_row      = (FH_W'(row_q) + FH_W'(1)) == eff_h;

  always_comb begin
    col_p1 = last_col ? '0 : col_q + COL_W'(1);
    if (last_col) begin
      col_p2 = COL_W'(1);
    end else if (next_last_col) begin
      col_p2 = '0;
    end else begin
      col_p2 = col_q + COL_W'(2);
    end
  end

  // Handshake: read ports must hold the current and next column; queue needs room for two
  assign in_stall_o = !(rd_valid_q && room2);
  assign accept     = in_valid_i && !in_stall_o;

  // Read ports track the column at hand and its right neighbor
  assign rd_a_addr = accept ? col_p1 : col_q;
  assign rd_b_addr = accept ? col_p2 : col_p1;

  // Shift the column: older takes the row above, newer the incoming pixel
  assign wr_entry.older = cur_entry.newer;
  assign wr_entry.newer = pixel_value_i;

  lmm4_line_store u_line_store (
    .clk_i       (clk_i),
    .wr_en_i     (accept),
    .wr_addr_i   (col_q),
    .wr_data_i   (wr_entry),
    .rd_a_addr_i (rd_a_addr),
    .rd_b_addr_i (rd_b_addr),
    .rd_a_data_o (cur_entry),
    .rd_b_data_o (nxt_entry)
  );

  // Position counters and read-port readiness
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= !geom_wr;
      if (geom_wr) begin
        col_q <= '0;
        row_q <= '0;
      end else if (accept) begin
        col_q <= col_p1;
        if (last_col) begin
          row_q <= last_row ? '0 : row_q + ROW_W'(1);
        end
      end
    end
  end

  // Left neighbor is the center of the previous transfer in the same row
  always_ff @(posedge clk_i) begin
    if (accept) begin
      left_q <= cur_entry.newer;
    end
  end

  // 4-neighbor compare on the pixel one row up
  assign k_ctr    = order_key(cur_entry.newer, pixel_signed_q);
  assign interior = (row_q >= ROW_W'(2)) && (col_q != '0) && !last_col;
  assign is_max   = interior
                 && (k_ctr >= order_key(cur_entry.older, pixel_signed_q))
                 && (k_ctr >= order_key(pixel_value_i, pixel_signed_q))
                 && (k_ctr >= order_key(left_q, pixel_signed_q))
                 && (k_ctr >= order_key(nxt_entry.newer, pixel_signed_q));

  // Result forming: mask of the pixel above, plus the border mask on the last row
  always_comb begin
    res0.is_max = is_max;
    res0.row    = row_q - ROW_W'(1);
    res0.col    = col_q;
    res0.done   = 1'b0;
    res1.is_max = 1'b0;
    res1.row    = row_q;
    res1.col    = col_q;
    res1.done   = last_col;
  end

  assign push0 = accept && (row_q != '0);
  assign push1 = push0 && last_row;

  lmm4_result_fifo u_result_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push0_i (push0),
    .data0_i (res0),
    .push1_i (push1),
    .data1_i (res1),
    .room2_o (room2),
    .valid_o (out_valid_o),
    .data_o  (res_out),
    .stall_i (out_stall_i)
  );

  assign is_local_max_o = res_out.is_max;
  assign out_row_o      = res_out.row;
  assign out_column_o   = res_out.col;
  assign frame_done_o   = res_out.done;

`ifndef SYNTH
  // A transfer only happens once the read ports hold valid window data
  a_accept_primed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> rd_valid_q)
    else $error("pixel taken before line store read data was ready");

  // Border pixels never carry a set mask bit
  a_border_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_local_max_o) |-> (out_row_o != '0 && out_column_o != '0))
    else $error("mask bit set on a border pixel");

  // End of frame marks only the bottom-right border pixel
  a_done_border: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_done_o) |-> (!is_local_max_o && out_column_o != '0))
    else $error("frame done on a non-border result");

  // Geometry change restarts the frame and blocks the next cycle
  a_geom_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    geom_wr |=> (col_q == '0 && row_q == '0 && in_stall_o))
    else $error("frame not restarted after geometry write");
`endif

endmodule

FILE: tb/tb_local_maximum_mask_4_neighbor_unit.sv
// Testbench for local_maximum_mask_4_neighbor_unit: raster pixel stream in, mask bits out,
// checked against a line-store predictor kept in step with every APB register write.
// Depends on lmm4_pkg and the unit itself.
`timescale 1ns / 1ps

module tb_local_maximum_mask_4_neighbor_unit;
  import lmm4_pkg::*;

  localparam int          CYCLE_LIMIT = 200_000;
  localparam int          SETTLE      = 8;   // cycles after the last mask bit before idle
  localparam int          HOLD_CYCLES = 48;  // long output hold-off
  localparam int          ITEM_TARGET = 550;
  localparam logic [1:0]  REG_SPARE   = 2'd3; // unmapped register slot

  typedef enum logic {ROW_PIXEL, ROW_WRITE} row_kind_e;
  typedef enum logic [1:0] {RX_FREE, RX_BLOCK, RX_COIN, RX_TOGGLE} rx_mode_e;

  // One directed stimulus row; typed rows carry the mask bit of the pixel above
  typedef struct packed {
    row_kind_e   kind;
    logic [1:0]  reg_idx;
    logic [31:0] value;
    logic        typed;
    logic        exp_max;
  } stim_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [PIXEL_BITS-1:0] pixel_value_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic                  is_local_max_o;
  logic [ROW_W-1:0]      out_row_o;
  logic [COL_W-1:0]      out_column_o;
  logic                  frame_done_o;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_AW-1:0]     paddr;
  logic [APB_DW-1:0]     pwdata;
  logic [APB_DW-1:0]     prdata;
  logic                  pready;

  local_maximum_mask_4_neighbor_unit uut (.*);

  // Predictor state: mirrored registers, line stores, raster position
  logic [FW_W-1:0]       cfg_width  = FW_W'(640);
  logic [FH_W-1:0]       cfg_height = FH_W'(480);
  logic                  cfg_signed = 1'b0;
  logic [PIXEL_BITS-1:0] line_older [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] line_newer [MAX_WIDTH];
  int                    cur_row = 0;
  int                    cur_col = 0;
  result_t               mask_due_q [$];

  int                    fail_count  = 0;
  int                    burst_left  = 0;
  int                    sent_items  = 0;
  logic                  hold_req    = 1'b0;
  logic [PIXEL_BITS-1:0] last_px     = '0;

  // 3x3 frames: a strict maximum that flips with the sign mode, then a tie in signed mode
  localparam int DIR_ROWS = 32;
  stim_row_t dir_rows [DIR_ROWS] = '{
    '{ROW_WRITE, REG_FRAME_WIDTH,  32'd3,         1'b0, 1'b0},
    '{ROW_WRITE, REG_FRAME_HEIGHT, 32'd3,         1'b0, 1'b0},
    '{ROW_WRITE, REG_PIXEL_SIGNED, 32'd0,         1'b0, 1'b0},
    '{ROW_WRITE, REG_SPARE,        32'hFFFF_FFFF, 1'b0, 1'b0},
    '{ROW_PIXEL, '0, 32'h0000, 1'b0, 1'b0},
    '{ROW_PIXEL, '0, 32'h7FFF, 1'b0, 1'b0},
    '{ROW_PIXEL, '0, 32'h0000, 1'b0, 1'b0},
    '{ROW_PIXEL, '0, 32'h7FFF, 1'b0, 1'b0},
    '{ROW_PIXEL, '0, 32'h8000, 1'b0, 1'b0},
    '{ROW_PIXEL, '0, 32'h7FFF, 1'b0, 1'b0},
    '{ROW_PIXEL, '0, 32'h0000, 1'b0, 1'b0},
    '{ROW_PIXEL, '0, 32'h7FFF, 1'b1, 1'b1},
    '{ROW_PIXEL, '0, 32'h0000, 1'b0, 1'b0},
    '{ROW_WRITE, REG_PIXEL_SIGNED, 32'd1,         1'b0, 1'b0},
    '{ROW_PIXEL, '0, 32'h0000, 1'b0, 1'b0},
    '{ROW_PIXEL, '0, 32'h7FFF, 1'b0, 1'b0},
    '{ROW_PIXEL, '0, 32'h0000, 1'b0, 1'b0},
    '{ROW_PIXEL, '0, 32'h7FFF, 1'b0, 1'b0},
    '{ROW_PIXEL, '0, 32'h8000, 1'b0, 1'b0},
    '{ROW_PIXEL, '0, 32'h7FFF, 1'b0, 1'b0},
    '{ROW_PIXEL, '0, 32'h0000, 1'b0, 1'b0},
    '{ROW_PIXEL, '0, 32'h7FFF, 1'b1, 1'b0},
    '{ROW_PIXEL, '0, 32'h0000, 1'b0, 1'b0},
    '{ROW_PIXEL, '0, 32'h7FFF, 1'b0, 1'b0},
    '{ROW_PIXEL, '0, 32'hFFFF, 1'b0, 1'b0},
    '{ROW_PIXEL, '0, 32'h7FFF, 1'b0, 1'b0},
    '{ROW_PIXEL, '0, 32'hFFFF, 1'b0, 1'b0},
    '{ROW_PIXEL, '0, 32'h0000, 1'b0, 1'b0},
    '{ROW_PIXEL, '0, 32'h0000, 1'b0, 1'b0},
    '{ROW_PIXEL, '0, 32'h8000, 1'b0, 1'b0},
    '{ROW_PIXEL, '0, 32'hFFFF, 1'b1, 1'b1},
    '{ROW_PIXEL, '0, 32'h8000, 1'b0, 1'b0}
  };

  function automatic void note_fail(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("mismatch %0d: %s", fail_count, msg);
  endfunction

  // Unsigned ordering key of a sample under the current sign mode
  function automatic logic [PIXEL_BITS-1:0] rank(input logic [PIXEL_BITS-1:0] v);
    return v ^ {cfg_signed, {(PIXEL_BITS-1){1'b0}}};
  endfunction

  // Mask bits caused by one accepted pixel; typed rows override the upper bit
  function automatic void track_pixel(input logic [PIXEL_BITS-1:0] px, input logic typed,
                                      input logic exp_max);
    int                    w = (cfg_width < MIN_DIM) ? MIN_DIM :
                               (cfg_width > MAX_WIDTH) ? MAX_WIDTH : int'(cfg_width);
    int                    h = (cfg_height < MIN_DIM) ? MIN_DIM :
                               (cfg_height > MAX_HEIGHT) ? MAX_HEIGHT : int'(cfg_height);
    int                    r = cur_row;
    int                    c = cur_col;
    logic [PIXEL_BITS-1:0] up, ctr, lft, rgt;
    logic                  hit;
    result_t               due_item;
    if (r >= 1) begin
      up  = line_older[c];
      ctr = line_newer[c];
      line_older[c] = ctr;
      line_newer[c] = px;
      hit = 1'b0;
      if (r >= 2 && c >= 1 && c + 2 <= w) begin
        lft = line_older[c-1];
        rgt = line_newer[c+1];
        hit = rank(ctr) >= rank(up) && rank(ctr) >= rank(px) &&
              rank(ctr) >= rank(lft) && rank(ctr) >= rank(rgt);
      end
      due_item = '{is_max: typed ? exp_max : hit, row: ROW_W'(r - 1),
                   col: COL_W'(c), done: 1'b0};
      mask_due_q = {mask_due_q, due_item};
      // last row also reports its own border bit
      if (r + 1 >= h) begin
        due_item = '{is_max: 1'b0, row: ROW_W'(r), col: COL_W'(c), done: (c + 1 >= w)};
        mask_due_q = {mask_due_q, due_item};
      end
    end else begin
      line_older[c] = line_newer[c];
      line_newer[c] = px;
    end
    if (c + 1 >= w) begin
      cur_col = 0;
      cur_row = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      cur_col = c + 1;
    end
  endfunction

  // Random samples: full range, around the sign boundary, extremes, near-plateaus
  function automatic logic [PIXEL_BITS-1:0] pick_pixel();
    logic [PIXEL_BITS-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = PIXEL_BITS'($urandom);
      4, 5:       v = 16'h7FFE + PIXEL_BITS'($urandom_range(0, 3));
      6: begin
        case ($urandom_range(0, 3))
          0:       v = '0;
          1:       v = '1;
          2:       v = 16'h8000;
          default: v = 16'h7FFF;
        endcase
      end
      default:    v = last_px + PIXEL_BITS'($urandom_range(0, 2)) - 1'b1;
    endcase
    last_px = v;
    return v;
  endfunction

  // Offer one pixel in bursts with random gaps; predict on transfer
  task automatic offer_pixel(input logic [PIXEL_BITS-1:0] px, input logic typed,
                             input logic exp_max);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i    <= 1'b0;
        pixel_value_i <= PIXEL_BITS'($urandom);
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i    <= 1'b1;
    pixel_value_i <= px;
    do @(posedge clk_i); while (in_stall_o);
    track_pixel(px, typed, exp_max);
    sent_items++;
  endtask

  // Stop sending and wait until every mask bit is back and the pipe is empty
  task automatic settle_idle();
    in_valid_i <= 1'b0;
    while (mask_due_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // One APB setup+access; leaves psel/penable up so transfers can run back to back
  task automatic apb_access(input logic wr, input logic [1:0] idx, input logic [31:0] wd,
                            output logic [31:0] rd);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= APB_AW'({idx, 2'b00});
    pwdata  <= wd;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rd = prdata;
  endtask

  task automatic check_reg(input logic [1:0] idx, input logic [31:0] want);
    logic [31:0] rd;
    apb_access(1'b0, idx, '0, rd);
    if (rd !== want) note_fail($sformatf("register %0d readback: expected %0h, got %0h",
                                         idx, want, rd));
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
    logic [31:0] rd;
    settle_idle();
    apb_access(1'b1, idx, val, rd);
    case (idx)
      REG_FRAME_WIDTH: begin
        cfg_width = val[FW_W-1:0];
        cur_row   = 0;
        cur_col   = 0;
        check_reg(idx, 32'(val[FW_W-1:0]));
      end
      REG_FRAME_HEIGHT: begin
        cfg_height = val[FH_W-1:0];
        cur_row    = 0;
        cur_col    = 0;
        check_reg(idx, 32'(val[FH_W-1:0]));
      end
      REG_PIXEL_SIGNED: begin
        cfg_signed = val[0];
        check_reg(idx, 32'(val[0]));
      end
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Reconfigure (a register is rewritten when it changes, or now and then anyway), then send n pixels
  task automatic run_phase(input int w, input int h, input logic sgn, input int n,
                           input logic hold);
    if (FW_W'(w) != cfg_width || $urandom_range(0, 3) == 0)
      cfg_write(REG_FRAME_WIDTH, 32'(w));
    if (FH_W'(h) != cfg_height || $urandom_range(0, 3) == 0)
      cfg_write(REG_FRAME_HEIGHT, 32'(h));
    if (sgn != cfg_signed || $urandom_range(0, 3) == 0)
      cfg_write(REG_PIXEL_SIGNED, 32'(sgn));
    if (hold) hold_req = 1'b1;
    repeat (n) offer_pixel(pick_pixel(), 1'b0, 1'b0);
  endtask

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Output stall pattern, with an occasional long hold-off on request
  initial begin : rx_stall_gen
    rx_mode_e mode;
    int       seg_len;
    out_stall_i <= 1'b0;
    forever begin
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        mode    = rx_mode_e'($urandom_range(0, 3));
        seg_len = $urandom_range(1, 16);
        repeat (seg_len) begin
          case (mode)
            RX_FREE:  out_stall_i <= 1'b0;
            RX_BLOCK: out_stall_i <= 1'b1;
            RX_COIN:  out_stall_i <= 1'($urandom_range(0, 1));
            default:  out_stall_i <= ~out_stall_i;
          endcase
          @(posedge clk_i);
        end
      end
    end
  end

  // Compare every mask transfer with the oldest pending prediction
  always @(posedge clk_i) begin : mask_check
    result_t due;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (mask_due_q.size() == 0) begin
        note_fail($sformatf("unexpected mask transfer at (%0d,%0d)", out_row_o, out_column_o));
      end else begin
        due = mask_due_q.pop_front();
        if (is_local_max_o !== due.is_max)
          note_fail($sformatf("is_local_max at (%0d,%0d): expected %0b, got %0b",
                              due.row, due.col, due.is_max, is_local_max_o));
        if (out_row_o !== due.row)
          note_fail($sformatf("out_row: expected %0d, got %0d", due.row, out_row_o));
        if (out_column_o !== due.col)
          note_fail($sformatf("out_column: expected %0d, got %0d", due.col, out_column_o));
        if (frame_done_o !== due.done)
          note_fail($sformatf("frame_done at (%0d,%0d): expected %0b, got %0b",
                              due.row, due.col, due.done, frame_done_o));
      end
    end
  end

  // Watchdog
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin : main_seq
    int n;
    in_valid_i    <= 1'b0;
    pixel_value_i <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    rst_ni        <= 1'b0;
    for (int i = 0; i < MAX_WIDTH; i++) begin
      line_older[i] = '0;
      line_newer[i] = '0;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset values, then a stream at the reset geometry ending mid-row
    check_reg(REG_FRAME_WIDTH, 32'd640);
    check_reg(REG_FRAME_HEIGHT, 32'd480);
    check_reg(REG_PIXEL_SIGNED, 32'd0);
    psel    <= 1'b0;
    penable <= 1'b0;
    hold_req = 1'b1;
    repeat (24) offer_pixel(pick_pixel(), 1'b0, 1'b0);

    // Directed frames
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_WRITE)
        cfg_write(dir_rows[i].reg_idx, dir_rows[i].value);
      else
        offer_pixel(dir_rows[i].value[PIXEL_BITS-1:0], dir_rows[i].typed, dir_rows[i].exp_max);
    end

    // Clamped geometries at the low end, then small frames
    run_phase(0, 2, 1'b0, 30, 1'b0);
    run_phase(1, 0, 1'b1, 25, 1'b0);
    run_phase(2, 1, 1'b0, 25, 1'b0);
    run_phase(5, 4, 1'b1, 60, 1'b1);
    run_phase(7, 5, 1'b0, 70, 1'b0);
    run_phase(16, 6, 1'b1, 100, 1'b0);

    // Width and height above the maximum: a short stretch each
    run_phase(2047, 3, 1'b1, 40, 1'b0);
    run_phase(3, 8191, 1'b0, 40, 1'b0);

    // Random small geometries until enough pixels went through
    while (sent_items < ITEM_TARGET) begin
      n = $urandom_range(20, 60);
      run_phase($urandom_range(3, 8), $urandom_range(3, 7), 1'($urandom_range(0, 1)), n,
                $urandom_range(0, 3) == 0);
    end

    settle_idle();
    if (fail_count == 0 && mask_due_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/lmm4_pkg.sv
sv/lmm4_line_store.sv
sv/lmm4_result_fifo.sv
sv/local_maximum_mask_4_neighbor_unit.sv
tb/tb_local_maximum_mask_4_neighbor_unit.sv
